FILE: sv/mmbr_pkg.sv
// Shared types and constants for the moving-mean baseline removal block.
// No dependencies; the other files that use this package refer to it by scoped names.
package mmbr_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int OUT_W      = SAMPLE_W + 1;
    localparam int SUM_W      = 30;
    localparam int MAG_W      = SUM_W - 1;
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = 6;
    localparam int WIN_W      = 6;
    localparam int S_W        = 5;
    localparam int MARGIN_W   = 4;
    localparam int IDX_W      = 16;
    localparam int CNT_W      = 6;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [WIN_W-1:0] MAX_WINDOW = 6'd32;
    localparam logic [IDX_W-1:0] MAX_BLOCK  = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    block_end;
        logic                    block_error;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

FILE: sv/mmbr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mmbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/mmbr_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on mmbr_pkg.
module mmbr_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [mmbr_pkg::SUM_W-1:0]     num,
    input  logic [mmbr_pkg::WIN_W-1:0]            den,
    output logic                                  done,
    output logic signed [mmbr_pkg::SAMPLE_W-1:0]  quo
);

    logic [mmbr_pkg::MAG_W-1:0]     mag_reg, mag_next;
    logic [mmbr_pkg::WIN_W-1:0]     rem_reg, rem_next;
    logic [mmbr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           neg_reg, neg_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [mmbr_pkg::SUM_W-1:0]     absn;
    logic [mmbr_pkg::WIN_W:0]       rem2;
    logic [mmbr_pkg::WIN_W:0]       diff;
    logic                           ge;
    logic [mmbr_pkg::SAMPLE_W-1:0]  qmag;

    assign absn = num[mmbr_pkg::SUM_W-1] ? (~num + 1'b1) : num;
    assign rem2 = {rem_reg, mag_reg[mmbr_pkg::MAG_W-1]};
    assign diff = rem2 - {1'b0, den};
    assign ge   = rem2 >= {1'b0, den};

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = absn[mmbr_pkg::MAG_W-1:0];
            rem_next  = '0;
            cnt_next  = mmbr_pkg::DIV_CNT_W'(mmbr_pkg::MAG_W);
            neg_next  = num[mmbr_pkg::SUM_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[mmbr_pkg::MAG_W-2:0], ge};
            rem_next = ge ? diff[mmbr_pkg::WIN_W-1:0] : rem2[mmbr_pkg::WIN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mmbr_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // quotient magnitude is at most 2^23, so the low 24 bits carry it whole
    assign qmag = mag_reg[mmbr_pkg::SAMPLE_W-1:0];
    assign quo  = neg_reg ? -$signed(qmag) : $signed(qmag);
    assign done = done_reg;

endmodule

FILE: sv/moving_mean_baseline_removal.sv
// Moving-mean baseline removal: top level with sequencer, ring RAM and divider.
// Depends on mmbr_pkg, mmbr_ram and mmbr_div.
//
// One input word is taken at a time, only while the sequencer is idle. A word
// that completes a local window reads the ring (one read port, one sample per
// cycle: the window samples, then the center sample), runs the serial divider,
// and then pushes each result word (1 to 2S+1 words) to the output register
// whenever that register is free. Words of a block that produce nothing leave
// the sequencer idle. Window, margin and mode are latched at the first sample
// of each block. The ring needs no clearing pass: every read lands on samples
// of the current block.
module moving_mean_baseline_removal (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mmbr_pkg::in_word_t                   in_word,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mmbr_pkg::out_word_t                  out_word,
    input  logic                                 cfg_we,
    input  logic [mmbr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmbr_pkg::WIN_W-1:0]           cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CTR  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    // configuration registers
    logic [mmbr_pkg::WIN_W-1:0]    cfg_win_reg;
    logic [mmbr_pkg::MARGIN_W-1:0] cfg_margin_reg;
    logic                          cfg_mode_reg;

    // per-block latched settings
    logic [mmbr_pkg::WIN_W-1:0]    blk_w_reg, blk_w_next;
    logic [mmbr_pkg::S_W-1:0]      blk_s_reg, blk_s_next;
    logic                          blk_mode_reg, blk_mode_next;

    logic [2:0]                    state_reg, state_next;
    logic [mmbr_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [mmbr_pkg::RING_AW-1:0]  wr_pos_reg, wr_pos_next;
    logic [mmbr_pkg::RING_AW-1:0]  cur_pos_reg, cur_pos_next;
    logic [mmbr_pkg::CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [mmbr_pkg::CNT_W-1:0]    emit_cnt_reg, emit_cnt_next;
    logic                          last_reg, last_next;
    logic                          err_reg, err_next;
    logic signed [mmbr_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic signed [mmbr_pkg::SAMPLE_W-1:0] ctr_reg, ctr_next;
    logic signed [mmbr_pkg::OUT_W-1:0]    val_reg, val_next;
    logic                          out_valid_reg, out_valid_next;
    mmbr_pkg::out_word_t           out_word_reg, out_word_next;

    // block settings as seen by the incoming word
    logic [mmbr_pkg::WIN_W-1:0]    eff_w;
    logic [mmbr_pkg::S_W-1:0]      eff_s;
    logic                          eff_mode;
    logic [mmbr_pkg::WIN_W-1:0]    clamp_w;
    logic [mmbr_pkg::CNT_W-1:0]    two_s;
    logic                          first;
    logic                          accept;

    logic                          ram_we;
    logic [mmbr_pkg::RING_AW-1:0]  ram_raddr;
    logic [mmbr_pkg::SAMPLE_W-1:0] ram_rdata;

    mmbr_pkg::div_ctl_t            div_ctl;
    logic signed [mmbr_pkg::SAMPLE_W-1:0] div_quo;
    logic                          out_free;

    mmbr_ram #(
        .WIDTH (mmbr_pkg::SAMPLE_W),
        .DEPTH (mmbr_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_pos_reg),
        .wdata (in_word.sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mmbr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_ctl.start),
        .num   (sum_reg),
        .den   (blk_w_reg),
        .done  (div_ctl.done),
        .quo   (div_quo)
    );

    assign div_ctl.start = (state_reg == ST_CTR);
    assign div_ctl.busy  = (state_reg == ST_DIV) && !div_ctl.done;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign ram_we   = accept;
    assign out_free = !out_valid_reg || out_ready;

    // zero window acts as one, oversize saturates
    always_comb
    begin
        clamp_w = cfg_win_reg;
        if (cfg_win_reg == '0)
        begin
            clamp_w = mmbr_pkg::WIN_W'(1);
        end
        else if (cfg_win_reg > mmbr_pkg::MAX_WINDOW)
        begin
            clamp_w = mmbr_pkg::MAX_WINDOW;
        end
    end

    assign first    = (idx_reg == '0);
    assign eff_w    = first ? clamp_w : blk_w_reg;
    assign eff_s    = first ? (clamp_w[mmbr_pkg::S_W:1] + mmbr_pkg::S_W'(cfg_margin_reg))
                            : blk_s_reg;
    assign eff_mode = first ? cfg_mode_reg : blk_mode_reg;
    assign two_s    = {eff_s, 1'b0};

    // window reads first, then the center sample
    always_comb
    begin
        if (rd_cnt_reg < blk_w_reg)
        begin
            ram_raddr = cur_pos_reg - mmbr_pkg::RING_AW'({blk_s_reg, 1'b0})
                        + rd_cnt_reg[mmbr_pkg::RING_AW-1:0];
        end
        else
        begin
            ram_raddr = cur_pos_reg - mmbr_pkg::RING_AW'(blk_s_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        blk_w_next     = blk_w_reg;
        blk_s_next     = blk_s_reg;
        blk_mode_next  = blk_mode_reg;
        idx_next       = idx_reg;
        wr_pos_next    = wr_pos_reg;
        cur_pos_next   = cur_pos_reg;
        rd_cnt_next    = rd_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        sum_next       = sum_reg;
        ctr_next       = ctr_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    blk_w_next    = eff_w;
                    blk_s_next    = eff_s;
                    blk_mode_next = eff_mode;
                    cur_pos_next  = wr_pos_reg;
                    wr_pos_next   = wr_pos_reg + 1'b1;
                    last_next     = in_word.last;
                    err_next      = 1'b0;
                    sum_next      = '0;
                    rd_cnt_next   = '0;
                    if (idx_reg >= mmbr_pkg::IDX_W'(two_s))
                    begin
                        // leading repeats, the word itself, trailing repeats
                        emit_cnt_next = mmbr_pkg::CNT_W'(1)
                            + ((idx_reg == mmbr_pkg::IDX_W'(two_s))
                               ? mmbr_pkg::CNT_W'(eff_s) : '0)
                            + (in_word.last ? mmbr_pkg::CNT_W'(eff_s) : '0);
                        state_next = ST_READ;
                    end
                    else if (in_word.last)
                    begin
                        // short block
                        emit_cnt_next = mmbr_pkg::CNT_W'(1);
                        err_next      = 1'b1;
                        val_next      = '0;
                        state_next    = ST_EMIT;
                    end
                    if (in_word.last)
                    begin
                        idx_next = '0;
                    end
                    else if (idx_reg != mmbr_pkg::MAX_BLOCK)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_cnt_reg != '0)
                begin
                    sum_next = sum_reg + mmbr_pkg::SUM_W'($signed(ram_rdata));
                end
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == blk_w_reg)
                begin
                    state_next = ST_CTR;
                end
            end
            ST_CTR:
            begin
                ctr_next   = $signed(ram_rdata);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_ctl.done)
                begin
                    val_next = blk_mode_reg
                        ? (mmbr_pkg::OUT_W'(ctr_reg) - mmbr_pkg::OUT_W'(div_quo))
                        : mmbr_pkg::OUT_W'(div_quo);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.value       = val_reg;
                    out_word_next.block_end   = last_reg && (emit_cnt_reg == mmbr_pkg::CNT_W'(1));
                    out_word_next.block_error = err_reg;
                    emit_cnt_next             = emit_cnt_reg - 1'b1;
                    if (emit_cnt_reg == mmbr_pkg::CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_win_reg    <= 6'd8;
            cfg_margin_reg <= '0;
            cfg_mode_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mmbr_pkg::CFG_WINDOW: cfg_win_reg    <= cfg_data;
                mmbr_pkg::CFG_MARGIN: cfg_margin_reg <= cfg_data[mmbr_pkg::MARGIN_W-1:0];
                mmbr_pkg::CFG_MODE:   cfg_mode_reg   <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            blk_w_reg     <= 6'd8;
            blk_s_reg     <= 5'd4;
            blk_mode_reg  <= 1'b1;
            idx_reg       <= '0;
            wr_pos_reg    <= '0;
            rd_cnt_reg    <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blk_w_reg     <= blk_w_next;
            blk_s_reg     <= blk_s_next;
            blk_mode_reg  <= blk_mode_next;
            idx_reg       <= idx_next;
            wr_pos_reg    <= wr_pos_next;
            rd_cnt_reg    <= rd_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_pos_reg  <= cur_pos_next;
        last_reg     <= last_next;
        err_reg      <= err_next;
        sum_reg      <= sum_next;
        ctr_reg      <= ctr_next;
        val_reg      <= val_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.done |-> (state_reg == ST_DIV))
        else $error("divider done outside wait state");

    // emission never starts with nothing to send
    a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (emit_cnt_reg != '0))
        else $error("emit state with zero count");

    // ring is written only by an accepted word in idle
    a_ring_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_IDLE) && !div_ctl.busy))
        else $error("ring write outside idle");

endmodule

FILE: dv/tb.sv
// Testbench for moving_mean_baseline_removal: random and directed sample blocks.
// Depends on mmbr_pkg and the block's RTL; predicts every result word itself.
module tb;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    mmbr_pkg::in_word_t             in_word;
    logic                           out_valid;
    logic                           out_ready;
    mmbr_pkg::out_word_t            out_word;
    logic                           cfg_we;
    logic [mmbr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mmbr_pkg::WIN_W-1:0]     cfg_data;

    moving_mean_baseline_removal DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // pending input words; a word with phase_mark set is a drain marker:
    // the driver waits until every expected word has come, then may write config
    typedef struct {
        mmbr_pkg::in_word_t         w;
        bit                         phase_mark;
        bit [2:0]                   cfg_en;
        logic [mmbr_pkg::WIN_W-1:0] cfg_val [3];
    } pend_t;

    pend_t               pending_q[$];
    mmbr_pkg::out_word_t expected_q[$];

    // predictor state: current settings, per-block latches, sample history
    logic [mmbr_pkg::WIN_W-1:0]    set_window = 6'd8;
    logic [mmbr_pkg::MARGIN_W-1:0] set_margin = '0;
    logic                          set_mode = 1'b1;
    int                            blk_w, blk_s;
    logic                          blk_mode;
    int                            fill_count = 0;
    logic signed [mmbr_pkg::SAMPLE_W-1:0] hist [mmbr_pkg::RING_DEPTH] = '{default: '0};
    int                            hist_pos = 0;

    int  errors = 0;
    int  mismatches = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  blocks_done = 0;
    int  short_blocks = 0;
    int  queued_words = 0;
    bit  done_stim;

    function automatic mmbr_pkg::out_word_t mk_word(logic signed [mmbr_pkg::OUT_W-1:0] v,
                                                    logic e, logic er);
        mmbr_pkg::out_word_t o;
        o.value = v;
        o.block_end = e;
        o.block_error = er;
        return o;
    endfunction

    // back = 0 is the sample just stored
    function automatic logic signed [mmbr_pkg::SAMPLE_W-1:0] hist_back(int back);
        return hist[(hist_pos + mmbr_pkg::RING_DEPTH - back) % mmbr_pkg::RING_DEPTH];
    endfunction

    task automatic predict_baseline(mmbr_pkg::in_word_t w);
        int w_eff;
        longint sum, mean, val;
        if (fill_count == 0)
        begin
            w_eff = (set_window == 0) ? 1
                  : (set_window > mmbr_pkg::MAX_WINDOW ? int'(mmbr_pkg::MAX_WINDOW)
                                                       : int'(set_window));
            blk_w = w_eff;
            blk_s = w_eff / 2 + int'(set_margin);
            blk_mode = set_mode;
        end
        hist[hist_pos] = w.sample;
        if (fill_count >= 2 * blk_s)
        begin
            sum = 0;
            for (int k = 0; k < blk_w; k++)
                sum += hist_back(2 * blk_s - k);
            mean = sum / blk_w;
            val = blk_mode ? (longint'(hist_back(blk_s)) - mean) : mean;
            if (fill_count == 2 * blk_s)
                for (int k = 0; k < blk_s; k++)
                    expected_q.push_back(mk_word(mmbr_pkg::OUT_W'(val), 1'b0, 1'b0));
            expected_q.push_back(mk_word(mmbr_pkg::OUT_W'(val), w.last && blk_s == 0, 1'b0));
            if (w.last)
                for (int k = 0; k < blk_s; k++)
                    expected_q.push_back(mk_word(mmbr_pkg::OUT_W'(val), k + 1 == blk_s, 1'b0));
        end
        else if (w.last)
        begin
            expected_q.push_back(mk_word('0, 1'b1, 1'b1));
            short_blocks++;
        end
        if (w.last)
        begin
            fill_count = 0;
            blocks_done++;
        end
        else if (fill_count < 65535)
            fill_count++;
        hist_pos = (hist_pos + 1) % mmbr_pkg::RING_DEPTH;
    endtask

    // ---- stimulus builders ----
    function automatic logic signed [mmbr_pkg::SAMPLE_W-1:0] rand_sample(int kind);
        case (kind)
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return mmbr_pkg::SAMPLE_W'($urandom_range(0, 200) - 100);
            default: return mmbr_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic add_word(logic signed [mmbr_pkg::SAMPLE_W-1:0] s, logic l);
        pend_t p;
        p.w.sample = s;
        p.w.last = l;
        p.phase_mark = 0;
        p.cfg_en = '0;
        pending_q.push_back(p);
        queued_words++;
    endtask

    task automatic add_phase(logic [mmbr_pkg::WIN_W-1:0] win,
                             logic [mmbr_pkg::MARGIN_W-1:0] mar, logic md);
        pend_t p;
        p.w = '0;
        p.phase_mark = 1;
        p.cfg_en = 3'b111;
        p.cfg_val[mmbr_pkg::CFG_WINDOW] = win;
        p.cfg_val[mmbr_pkg::CFG_MARGIN] = mmbr_pkg::WIN_W'(mar);
        p.cfg_val[mmbr_pkg::CFG_MODE] = mmbr_pkg::WIN_W'(md);
        pending_q.push_back(p);
    endtask

    task automatic add_block(int len, int kind);
        for (int i = 0; i < len; i++)
            add_word(rand_sample(kind), i == len - 1);
    endtask

    task automatic set_value(int r, logic [mmbr_pkg::WIN_W-1:0] v);
        if (r == mmbr_pkg::CFG_WINDOW)
            set_window = v;
        else if (r == mmbr_pkg::CFG_MARGIN)
            set_margin = v[mmbr_pkg::MARGIN_W-1:0];
        else
            set_mode = v[0];
    endtask

    // ---- driver ----
    int    gap;
    bit    cfg_pending;
    bit    cfg_fire;
    pend_t cur;
    int    settle;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
            cfg_we   <= 1'b0;
            cfg_index <= mmbr_pkg::CFG_WINDOW;
            cfg_data <= '0;
            gap = 0;
            cfg_pending = 0;
            cfg_fire = 0;
            settle = 0;
            done_stim = 0;
        end
        else
        begin
            cfg_fire = 0;
            if (in_valid && in_ready)
            begin
                predict_baseline(in_word);
                words_in++;
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (!(in_valid && !in_ready))
            begin
                if (cfg_pending)
                begin
                    // idle block: wait for drain plus latency margin, then write
                    if (expected_q.size() == 0)
                    begin
                        if (settle < 200)
                            settle++;
                        else
                        begin
                            for (int r = 0; r < 3; r++)
                                if (cur.cfg_en[r])
                                begin
                                    cur.cfg_en[r] = 0;
                                    cfg_fire = 1;
                                    cfg_index <= mmbr_pkg::CFG_IDX_W'(r);
                                    cfg_data <= cur.cfg_val[r];
                                    set_value(r, cur.cfg_val[r]);
                                    break;
                                end
                            if (cur.cfg_en == 0)
                                cfg_pending = 0;
                        end
                    end
                    in_valid <= 1'b0;
                end
                else if (gap > 0)
                begin
                    gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur = pending_q.pop_front();
                    if (cur.phase_mark)
                    begin
                        cfg_pending = 1;
                        settle = 0;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        in_valid <= 1'b1;
                        in_word <= cur.w;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                    done_stim = 1;
                end
            end
            cfg_we <= cfg_fire;
        end
    end

    // ---- monitor ----
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                mmbr_pkg::out_word_t exp_w;
                words_out++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("ERROR: unexpected word value=%0d end=%b err=%b",
                                 out_word.value, out_word.block_end, out_word.block_error);
                end
                else
                begin
                    exp_w = expected_q.pop_front();
                    if (exp_w !== out_word)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("ERROR: exp value=%0d end=%b err=%b got value=%0d end=%b err=%b",
                                     exp_w.value, exp_w.block_end, exp_w.block_error,
                                     out_word.value, out_word.block_end, out_word.block_error);
                    end
                end
                stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---- stimulus and end of run ----
    int idle_cycles;
    int tail;

    initial
    begin
        // directed: reset settings, extremes of samples, short block
        add_block(9, 0);
        add_block(9, 1);
        add_block(3, 2);              // short block: error word
        add_phase(6'd0, 4'd0, 1'b0);  // window zero acts as one, S = 0
        add_word(24'sh800000, 1'b1);  // single-sample block
        add_block(4, 1);
        add_phase(6'd63, 4'd15, 1'b1); // saturates to 32, S = 31, needs 63
        add_block(63, 0);
        add_phase(6'd32, 4'd0, 1'b0);  // S = 16, needs 33
        add_block(33, 3);
        add_block(32, 3);             // one short of 2S+1

        // random phases
        while (queued_words < 440)
        begin
            int wv, mv;
            wv = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 8);
            mv = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 3);
            add_phase(mmbr_pkg::WIN_W'(wv), mmbr_pkg::MARGIN_W'(mv), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 5))
            begin
                int s_eff;
                s_eff = (wv == 0 ? 1 : (wv > 32 ? 32 : wv)) / 2 + mv;
                if ($urandom_range(0, 5) == 0)
                    add_block($urandom_range(1, 2 * s_eff + 1), $urandom_range(0, 3));
                else
                    add_block(2 * s_eff + 1 + $urandom_range(0, 20), $urandom_range(2, 3));
            end
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n = 1'b1;

        idle_cycles = 0;
        while (!(done_stim && expected_q.size() == 0) && idle_cycles < 20000)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        tail = 0;
        while (tail < 300 && idle_cycles < 20000)
        begin
            @(posedge clk);
            tail++;
        end
        $display("Ran %0d samples in %0d blocks (%0d short), checked %0d result words.",
                 words_in, blocks_done, short_blocks, words_out);
        if (idle_cycles >= 20000)
            $display("Test completed with failures");
        else if (errors == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
